// ----- rtl/bc1_to_bc5_block_texel_decoder_top_macros.svh -----
// Assertion macros shared by the queue and back parts of the texel decoder.
`ifndef BC1_TO_BC5_BLOCK_TEXEL_DECODER_TOP_MACROS_SVH
`define BC1_TO_BC5_BLOCK_TEXEL_DECODER_TOP_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define BCTD_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define BCTD_ASSERT_IMPLY(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define BCTD_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- rtl/bctd_pkg.sv -----
// Types, constants and decode functions of the block texel decoder.
`default_nettype none

package bctd_pkg;

   localparam int HALF_W              = 64;
   localparam int PIXEL_W             = 32;
   localparam int POS_W               = 4;
   localparam int FMT_W               = 3;
   localparam int TEXELS              = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef logic [FMT_W-1:0] fmt_type;

   localparam fmt_type FMT_BC1 = 3'd0;
   localparam fmt_type FMT_BC2 = 3'd1;
   localparam fmt_type FMT_BC3 = 3'd2;
   localparam fmt_type FMT_BC4 = 3'd3;
   localparam fmt_type FMT_BC5 = 3'd4;

   typedef logic [6:0] weight_type;

   // One classified block as it waits for the texel datapath.
   typedef struct packed {
      fmt_type           fmt;
      logic              four_colour;
      logic              lo_gt;
      logic              hi_gt;
      logic [HALF_W-1:0] lo;
      logic [HALF_W-1:0] hi;
   } blk_entry_type;

   // ((64-w)*e0 + w*e1 + 32) >> 6 on 8-bit endpoints.
   function automatic logic [7:0] mix_chan(logic [7:0] e0, logic [7:0] e1, weight_type w);
      logic [6:0]  wc;
      logic [14:0] sum;
      wc  = 7'd64 - w;
      sum = ({8'd0, wc} * {7'd0, e0}) + ({8'd0, w} * {7'd0, e1}) + 15'd32;
      return sum[13:6];
   endfunction

   // Mixes two 565 endpoints and widens the result to 8-bit RGB.
   function automatic logic [23:0] colour_rgb(logic [15:0] c0, logic [15:0] c1,
                                              weight_type w);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      r = mix_chan({3'd0, c0[15:11]}, {3'd0, c1[15:11]}, w);
      g = mix_chan({2'd0, c0[10:5]}, {2'd0, c1[10:5]}, w);
      b = mix_chan({3'd0, c0[4:0]}, {3'd0, c1[4:0]}, w);
      return {r[4:0], r[4:2], g[5:0], g[5:4], b[4:0], b[4:2]};
   endfunction

   // Weight of a 3-bit alpha code in eight-value or six-value mode.
   function automatic weight_type alpha_weight(logic gt, logic [2:0] code);
      weight_type w;
      case (code)
         3'd0:    w = 7'd0;
         3'd1:    w = 7'd64;
         3'd2:    w = gt ? 7'd9  : 7'd13;
         3'd3:    w = gt ? 7'd18 : 7'd26;
         3'd4:    w = gt ? 7'd27 : 7'd38;
         3'd5:    w = gt ? 7'd37 : 7'd51;
         3'd6:    w = gt ? 7'd46 : 7'd0;
         3'd7:    w = gt ? 7'd55 : 7'd0;
         default: w = 7'd0;
      endcase
      return w;
   endfunction

   // Interpolated 8-bit channel; six-value mode has fixed black and white codes.
   function automatic logic [7:0] alpha_value(logic [7:0] a0, logic [7:0] a1, logic gt,
                                              logic [2:0] code);
      logic [7:0] v;
      v = mix_chan(a0, a1, alpha_weight(gt, code));
      if (!gt && code == 3'd6) begin
         v = 8'h00;
      end else if (!gt && code == 3'd7) begin
         v = 8'hFF;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/bctd_if.sv -----
// Handshake channel interfaces of the block texel decoder.
`default_nettype none

interface bctd_req_if import bctd_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] block_low;
   logic [HALF_W-1:0] block_high;

   modport source (output valid, output block_low, output block_high, input ready);
   modport sink   (input valid, input block_low, input block_high, output ready);
endinterface

interface bctd_rsp_if import bctd_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_argb;
   logic [POS_W-1:0]   texel_position;
   logic               last_texel;

   modport source (output valid, output pixel_argb, output texel_position,
                   output last_texel, input ready);
   modport sink   (input valid, input pixel_argb, input texel_position,
                   input last_texel, output ready);
endinterface

interface bctd_csr_if import bctd_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [FMT_W-1:0]  block_format;

   modport source (output valid, output block_format, input ready);
   modport sink   (input valid, input block_format, output ready);
endinterface

`default_nettype wire

// ----- rtl/bctd_front.sv -----
// Front part: format register, block intake and per-block classification.
`default_nettype none

module bctd_front import bctd_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   bctd_req_if.sink    req_chan,
   bctd_csr_if.sink    csr_chan,
   output logic        entry_valid,
   output blk_entry_type entry,
   input  wire logic   entry_ready
);

   fmt_type       format_ff;
   fmt_type       format_in;
   logic          hold_valid_ff;
   logic          hold_valid_in;
   blk_entry_type hold_entry_ff;
   blk_entry_type hold_entry_in;
   blk_entry_type cls;
   logic          accept;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !hold_valid_ff || entry_ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // Mode decisions are made once per block.
   always_comb begin
      cls.fmt         = format_ff;
      cls.lo          = req_chan.block_low;
      cls.hi          = req_chan.block_high;
      cls.lo_gt       = req_chan.block_low[7:0] > req_chan.block_low[15:8];
      cls.hi_gt       = req_chan.block_high[7:0] > req_chan.block_high[15:8];
      cls.four_colour = (format_ff != FMT_BC1) ||
                        (req_chan.block_low[15:0] >= req_chan.block_low[31:16]);
   end

   assign format_in     = (csr_chan.valid && csr_chan.ready) ? csr_chan.block_format
                                                             : format_ff;
   assign hold_valid_in = accept || (hold_valid_ff && !entry_ready);
   assign hold_entry_in = accept ? cls : hold_entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff     <= FMT_BC1;
         hold_valid_ff <= 1'b0;
      end else begin
         format_ff     <= format_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_entry_ff <= hold_entry_in;
   end

   assign entry_valid = hold_valid_ff;
   assign entry       = hold_entry_ff;

endmodule

`default_nettype wire

// ----- rtl/bctd_queue.sv -----
// Short block queue between the front and back parts.
`default_nettype none
`include "bc1_to_bc5_block_texel_decoder_top_macros.svh"

module bctd_queue import bctd_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   input  wire blk_entry_type push_entry,
   output logic               push_ready,
   output logic               pop_valid,
   output blk_entry_type      pop_entry,
   input  wire logic          pop_ready
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   blk_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `BCTD_ASSERT(a_q_bound, count_ff <= CNT_W'(DEPTH), "queue count above its depth")
   `BCTD_ASSERT_NEXT(a_q_fill, do_push && !do_pop, count_ff == $past(count_ff) + CNT_W'(1), "queue count did not rise on a push")
   `BCTD_ASSERT_IMPLY(a_q_ptr, count_ff == '0, wr_ptr_ff == rd_ptr_ff, "empty queue with pointers apart")

endmodule

`default_nettype wire

// ----- rtl/bctd_back.sv -----
// Back part: texel sequencer, texel datapath and output register.
`default_nettype none
`include "bc1_to_bc5_block_texel_decoder_top_macros.svh"

module bctd_back import bctd_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          head_valid,
   input  wire blk_entry_type head_entry,
   output logic               head_pop,
   bctd_rsp_if.source         rsp_chan
);

   localparam logic [POS_W-1:0] LAST_TEXEL = POS_W'(TEXELS - 1);

   logic [POS_W-1:0]   tex_idx_ff;
   logic [POS_W-1:0]   tex_idx_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [PIXEL_W-1:0] pixel_ff;
   logic [PIXEL_W-1:0] pixel_in;
   logic [POS_W-1:0]   pos_ff;
   logic               last_ff;
   logic               advance;
   logic               step;

   logic [HALF_W-1:0]  colour_half;
   logic [31:0]        colour_codes;
   logic [47:0]        lo_codes;
   logic [47:0]        hi_codes;
   logic [1:0]         sel;
   logic [5:0]         code_bit;
   logic [2:0]         lo_code;
   logic [2:0]         hi_code;
   logic [3:0]         nibble;
   weight_type         colour_w;
   logic               transparent;
   logic [23:0]        rgb;
   logic [7:0]         alpha_lo;
   logic [7:0]         alpha_hi;

   assign advance  = !rsp_valid_ff || rsp_chan.ready;
   assign step     = head_valid && advance;
   assign head_pop = step && (tex_idx_ff == LAST_TEXEL);

   assign tex_idx_in   = step ? tex_idx_ff + POS_W'(1) : tex_idx_ff;
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_chan.ready);

   // Field selection for the current texel.
   always_comb begin
      colour_half  = (head_entry.fmt == FMT_BC1) ? head_entry.lo : head_entry.hi;
      colour_codes = colour_half[63:32];
      lo_codes     = head_entry.lo[63:16];
      hi_codes     = head_entry.hi[63:16];
      sel          = colour_codes[{tex_idx_ff, 1'b0} +: 2];
      code_bit     = {2'd0, tex_idx_ff} + {1'd0, tex_idx_ff, 1'b0};
      lo_code      = lo_codes[code_bit +: 3];
      hi_code      = hi_codes[code_bit +: 3];
      nibble       = head_entry.lo[{tex_idx_ff, 2'b00} +: 4];
   end

   // Endpoints themselves are mixes with weight zero or full weight.
   always_comb begin
      case (sel)
         2'd0:    colour_w = 7'd0;
         2'd1:    colour_w = 7'd64;
         2'd2:    colour_w = head_entry.four_colour ? 7'd21 : 7'd32;
         2'd3:    colour_w = 7'd43;
         default: colour_w = 7'd0;
      endcase
      transparent = !head_entry.four_colour && (sel == 2'd3);
   end

   assign rgb      = colour_rgb(colour_half[15:0], colour_half[31:16], colour_w);
   assign alpha_lo = alpha_value(head_entry.lo[7:0], head_entry.lo[15:8],
                                 head_entry.lo_gt, lo_code);
   assign alpha_hi = alpha_value(head_entry.hi[7:0], head_entry.hi[15:8],
                                 head_entry.hi_gt, hi_code);

   always_comb begin
      case (head_entry.fmt)
         FMT_BC1: pixel_in = transparent ? '0 : {8'hFF, rgb};
         FMT_BC2: pixel_in = {nibble, nibble, rgb};
         FMT_BC3: pixel_in = {alpha_lo, rgb};
         FMT_BC4: pixel_in = {8'hFF, alpha_lo, alpha_lo, alpha_lo};
         FMT_BC5: pixel_in = {8'hFF, alpha_lo, alpha_hi, 8'h00};
         default: pixel_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tex_idx_ff   <= tex_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         pixel_ff <= pixel_in;
         pos_ff   <= tex_idx_ff;
         last_ff  <= tex_idx_ff == LAST_TEXEL;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.pixel_argb     = pixel_ff;
   assign rsp_chan.texel_position = pos_ff;
   assign rsp_chan.last_texel     = last_ff;

   `BCTD_ASSERT_NEXT(a_bk_wrap, head_pop, tex_idx_ff == '0, "texel counter not back at zero after a block")
   `BCTD_ASSERT_NEXT(a_bk_pos, step, pos_ff == $past(tex_idx_ff), "texel position does not follow the counter")
   `BCTD_ASSERT_IMPLY(a_bk_last, rsp_valid_ff, last_ff == (pos_ff == LAST_TEXEL), "last flag off the final texel")

endmodule

`default_nettype wire

// ----- rtl/bc1_to_bc5_block_texel_decoder_top.sv -----
// Top level of the BC1 to BC5 block texel decoder.
// The first texel item of a block passes the front hold register, the queue and the back part's
// output register; the remaining fifteen follow one a cycle while rsp_chan.ready stays high.
// The back part has a single texel datapath; the queue lets a new block be taken meanwhile.
// Reset (synchronous, active high) selects BC1, empties the queue and clears the texel counter.
`default_nettype none

module bc1_to_bc5_block_texel_decoder_top import bctd_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bctd_req_if.sink   req_chan,
   bctd_rsp_if.source rsp_chan,
   bctd_csr_if.sink   csr_chan
);

   // The front part holds the format register, takes one block item, and decides the
   // colour mode and both alpha modes before the block joins the queue.
   logic          front_valid;
   blk_entry_type front_entry;
   logic          front_ready;

   // The queue lets a new block be taken while the back part is still emitting the
   // texels of an earlier one. QUEUE_DEPTH must be two or more.
   logic          head_valid;
   blk_entry_type head_entry;
   logic          head_pop;

   bctd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_chan    (csr_chan),
      .entry_valid (front_valid),
      .entry       (front_entry),
      .entry_ready (front_ready)
   );

   bctd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_entry (front_entry),
      .push_ready (front_ready),
      .pop_valid  (head_valid),
      .pop_entry  (head_entry),
      .pop_ready  (head_pop)
   );

   // The back part walks the sixteen texels of the head block in row order and
   // releases the block with its last texel. Its output register decouples the
   // datapath from a stalled result channel.
   bctd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_pop   (head_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire
